>>> src/afbs_pkg.sv
// ----------------------------------------------------------------------------
// afbs_pkg: shared types and constants for the affine bilinear sampler
// Opcodes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package afbs_pkg;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_A11    = 3'd0,
    REG_A12    = 3'd1,
    REG_A13    = 3'd2,
    REG_A21    = 3'd3,
    REG_A22    = 3'd4,
    REG_A23    = 3'd5,
    REG_WIDTH  = 3'd6,
    REG_HEIGHT = 3'd7
  } reg_t;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic signed [31:0] COEF_ONE = 32'sd65536;
  localparam logic [6:0] SIZE_RESET = 7'd64;

endpackage

>>> src/affine_bilinear_sampler.sv
// Throughput: one item per cycle for writes and for samples with one channel
// while no held result waits on m_tready; a sample with more channels holds the
// input until the channel serialiser has sent all of its channels.
// The frame store is four banks split by row and column parity, one read each.
// Reset (rst, synchronous) clears the pipeline and loads register defaults;
// the frame store is not cleared and holds nothing defined until written.
// ----------------------------------------------------------------------------
// affine_bilinear_sampler: affine warp with bilinear blend and edge replicate
// Writes source bytes into a banked frame store and samples output pixels
// through a seven-stage pipeline: map, sum, clamp, address, read, weight, sum.
// ----------------------------------------------------------------------------
module affine_bilinear_sampler import afbs_pkg::*; #(
  parameter int MAX_SRC_W = 64,
  parameter int MAX_SRC_H = 64,
  parameter int CHANNELS  = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pos_col[5:0], pos_row[11:6], pixel_in[19:12]
  input  logic [2:0]  s_tuser,   // opcode[0], chan_sel[2:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // sample_value[15:0]
  output logic [1:0]  m_tuser,   // chan_out[1:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int CW  = $clog2(MAX_SRC_W);
  localparam int RW  = $clog2(MAX_SRC_H);
  localparam int WB  = (MAX_SRC_W + 1) / 2;
  localparam int HB  = (MAX_SRC_H + 1) / 2;
  localparam int BD  = WB * HB;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int CNW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  function automatic logic [BAW-1:0] bank_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
    return BAW'((32'(r) >> 1) * WB + (32'(c) >> 1));
  endfunction

  logic signed [31:0] coef_a11, coef_a12, coef_a13, coef_a21, coef_a22, coef_a23;
  logic [6:0] src_width, src_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a11 <= COEF_ONE;
      coef_a12 <= '0;
      coef_a13 <= '0;
      coef_a21 <= '0;
      coef_a22 <= COEF_ONE;
      coef_a23 <= '0;
      src_width <= SIZE_RESET;
      src_height <= SIZE_RESET;
    end else if (cfg_we) begin
      case (reg_t'(cfg_addr))
        REG_A11: coef_a11 <= cfg_wdata;
        REG_A12: coef_a12 <= cfg_wdata;
        REG_A13: coef_a13 <= cfg_wdata;
        REG_A21: coef_a21 <= cfg_wdata;
        REG_A22: coef_a22 <= cfg_wdata;
        REG_A23: coef_a23 <= cfg_wdata;
        REG_WIDTH: src_width <= cfg_wdata[6:0];
        REG_HEIGHT: src_height <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  logic [CW:0] w_sat;
  logic [RW:0] h_sat;
  logic signed [24:0] wm1, hm1;

  always_comb begin
    if (src_width < 7'd2) w_sat = (CW+1)'(2);
    else if (32'(src_width) > MAX_SRC_W) w_sat = (CW+1)'(MAX_SRC_W);
    else w_sat = (CW+1)'(src_width);
    if (src_height < 7'd2) h_sat = (RW+1)'(2);
    else if (32'(src_height) > MAX_SRC_H) h_sat = (RW+1)'(MAX_SRC_H);
    else h_sat = (RW+1)'(src_height);
  end

  assign wm1 = $signed(25'(w_sat)) - 25'sd1;
  assign hm1 = $signed(25'(h_sat)) - 25'sd1;

  logic en, last, hold_valid;
  logic [CNW-1:0] cnt;

  assign last = (cnt == CNW'(CHANNELS - 1));
  assign en = !hold_valid || (m_tready && last);
  assign s_tready = en;

  // stage 1: coordinate products
  logic st1_valid, st1_op, st1_ok;
  logic [5:0] st1_col, st1_row;
  logic [1:0] st1_chan;
  logic [7:0] st1_pix;
  logic signed [38:0] px_c, px_r, py_c, py_r;

  always_ff @(posedge clk) begin
    if (rst) st1_valid <= 1'b0;
    else if (en) st1_valid <= s_tvalid;
    if (en) begin
      st1_op <= s_tuser[0];
      st1_chan <= s_tuser[2:1];
      st1_col <= s_tdata[5:0];
      st1_row <= s_tdata[11:6];
      st1_pix <= s_tdata[19:12];
      st1_ok <= (32'(s_tdata[5:0]) < MAX_SRC_W) && (32'(s_tdata[11:6]) < MAX_SRC_H)
                && (32'(s_tuser[2:1]) < CHANNELS);
      px_c <= coef_a11 * $signed({1'b0, s_tdata[5:0]});
      px_r <= coef_a12 * $signed({1'b0, s_tdata[11:6]});
      py_c <= coef_a21 * $signed({1'b0, s_tdata[5:0]});
      py_r <= coef_a22 * $signed({1'b0, s_tdata[11:6]});
    end
  end

  // stage 2: source point
  logic st2_valid, st2_op, st2_ok;
  logic [5:0] st2_col, st2_row;
  logic [1:0] st2_chan;
  logic [7:0] st2_pix;
  logic signed [40:0] xs, ys;

  always_ff @(posedge clk) begin
    if (rst) st2_valid <= 1'b0;
    else if (en) st2_valid <= st1_valid;
    if (en) begin
      st2_op <= st1_op;
      st2_ok <= st1_ok;
      st2_col <= st1_col;
      st2_row <= st1_row;
      st2_chan <= st1_chan;
      st2_pix <= st1_pix;
      xs <= 41'(px_c) + 41'(px_r) + 41'(coef_a13);
      ys <= 41'(py_c) + 41'(py_r) + 41'(coef_a23);
    end
  end

  // stage 3: split and clamp
  logic signed [24:0] ix, iy;
  logic [CW-1:0] c0_next, c1_next;
  logic [RW-1:0] r0_next, r1_next;

  assign ix = xs[40:16];
  assign iy = ys[40:16];

  always_comb begin
    if (!ix[24] && ix < wm1) begin
      c0_next = CW'(ix);
      c1_next = CW'(ix + 25'sd1);
    end else if (ix[24]) begin
      c0_next = '0;
      c1_next = '0;
    end else begin
      c0_next = CW'(wm1);
      c1_next = CW'(wm1);
    end
    if (!iy[24] && iy < hm1) begin
      r0_next = RW'(iy);
      r1_next = RW'(iy + 25'sd1);
    end else if (iy[24]) begin
      r0_next = '0;
      r1_next = '0;
    end else begin
      r0_next = RW'(hm1);
      r1_next = RW'(hm1);
    end
  end

  logic st3_valid, st3_op, st3_ok;
  logic [5:0] st3_col, st3_row;
  logic [1:0] st3_chan;
  logic [7:0] st3_pix;
  logic [CW-1:0] c0, c1;
  logic [RW-1:0] r0, r1;
  logic [15:0] fa, fb;

  always_ff @(posedge clk) begin
    if (rst) st3_valid <= 1'b0;
    else if (en) st3_valid <= st2_valid;
    if (en) begin
      st3_op <= st2_op;
      st3_ok <= st2_ok;
      st3_col <= st2_col;
      st3_row <= st2_row;
      st3_chan <= st2_chan;
      st3_pix <= st2_pix;
      c0 <= c0_next;
      c1 <= c1_next;
      r0 <= r0_next;
      r1 <= r1_next;
      fa <= xs[15:0];
      fb <= ys[15:0];
    end
  end

  // stage 4: bank addresses and weights
  logic [BAW-1:0] addr_next [4];
  logic [3:0] we_next;
  logic [CW-1:0] wcol;
  logic [RW-1:0] wrow;
  logic [16:0] a1, b1;

  assign wcol = CW'(st3_col);
  assign wrow = RW'(st3_row);
  assign a1 = ONE_Q16 - 17'(fa);
  assign b1 = ONE_Q16 - 17'(fb);

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [RW-1:0] rs;
      logic [CW-1:0] cs;
      logic [1:0] bi;
      bi = 2'(b);
      rs = (r0[0] == bi[1]) ? r0 : r1;
      cs = (c0[0] == bi[0]) ? c0 : c1;
      we_next[b] = st3_valid && (st3_op == OP_WRITE) && st3_ok
                   && ({wrow[0], wcol[0]} == bi);
      addr_next[b] = (st3_op == OP_WRITE) ? bank_addr(wrow, wcol) : bank_addr(rs, cs);
    end
  end

  logic st4_valid, st4_sample;
  logic [3:0] st4_we;
  logic [BAW-1:0] st4_addr [4];
  logic [1:0] st4_chan;
  logic [7:0] st4_pix;
  logic [3:0] st4_par;
  logic [33:0] st4_w [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      st4_valid <= 1'b0;
      st4_we <= '0;
    end else if (en) begin
      st4_valid <= st3_valid;
      st4_we <= we_next;
    end
    if (en) begin
      st4_sample <= (st3_op == OP_SAMPLE);
      st4_addr <= addr_next;
      st4_chan <= st3_chan;
      st4_pix <= st3_pix;
      st4_par <= {r1[0], r0[0], c1[0], c0[0]};
      st4_w[0] <= 34'(a1) * 34'(b1);
      st4_w[1] <= 34'(fa) * 34'(b1);
      st4_w[2] <= 34'(a1) * 34'(fb);
      st4_w[3] <= 34'(fa) * 34'(fb);
    end
  end

  // stage 5: frame store banks
  logic [7:0] rd [4][CHANNELS];

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    for (genvar gk = 0; gk < CHANNELS; gk++) begin : g_chan
      logic [7:0] mem [BD];
      always_ff @(posedge clk) begin
        if (en) begin
          if (st4_we[gb] && (32'(st4_chan) == gk)) mem[st4_addr[gb]] <= st4_pix;
          rd[gb][gk] <= mem[st4_addr[gb]];
        end
      end
    end
  end

  logic st5_valid, st5_sample;
  logic [3:0] st5_par;
  logic [33:0] st5_w [4];

  always_ff @(posedge clk) begin
    if (rst) st5_valid <= 1'b0;
    else if (en) st5_valid <= st4_valid;
    if (en) begin
      st5_sample <= st4_sample;
      st5_par <= st4_par;
      st5_w <= st4_w;
    end
  end

  // stage 6: weighted neighbours
  logic [1:0] b00, b01, b10, b11;
  assign b00 = {st5_par[2], st5_par[0]};
  assign b01 = {st5_par[2], st5_par[1]};
  assign b10 = {st5_par[3], st5_par[0]};
  assign b11 = {st5_par[3], st5_par[1]};

  logic st6_valid, st6_sample;
  logic [41:0] prod [CHANNELS][4];

  always_ff @(posedge clk) begin
    if (rst) st6_valid <= 1'b0;
    else if (en) st6_valid <= st5_valid;
    if (en) begin
      st6_sample <= st5_sample;
      for (int k = 0; k < CHANNELS; k++) begin
        prod[k][0] <= 42'(rd[b00][k]) * 42'(st5_w[0]);
        prod[k][1] <= 42'(rd[b01][k]) * 42'(st5_w[1]);
        prod[k][2] <= 42'(rd[b10][k]) * 42'(st5_w[2]);
        prod[k][3] <= 42'(rd[b11][k]) * 42'(st5_w[3]);
      end
    end
  end

  // output hold and channel serialiser
  logic [43:0] acc [CHANNELS];
  logic [15:0] vals [CHANNELS];

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      acc[k] = 44'(prod[k][0]) + 44'(prod[k][1]) + 44'(prod[k][2]) + 44'(prod[k][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      cnt <= '0;
    end else if (en) begin
      hold_valid <= st6_valid && st6_sample;
      cnt <= '0;
    end else if (m_tready) begin
      cnt <= cnt + 1'b1;
    end
    if (en) begin
      for (int k = 0; k < CHANNELS; k++) vals[k] <= acc[k][39:24];
    end
  end

  assign m_tvalid = hold_valid;
  assign m_tdata = vals[cnt];
  assign m_tuser = 2'(cnt);
  assign m_tlast = last;

`ifndef ASSERT_OFF
  a_one_bank_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0(st4_we))
    else $error("more than one bank written in a cycle");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !m_tready) |=> (hold_valid && $stable(cnt)))
    else $error("result dropped while stalled");

  a_sample_load: assert property (@(posedge clk) disable iff (rst)
    (en && st6_valid && st6_sample) |=> (hold_valid && cnt == '0))
    else $error("sample did not reach output hold");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (en && !(st6_valid && st6_sample)) |=> !hold_valid)
    else $error("result without a sample");
`endif

endmodule

>>> verif/tb_affine_bilinear_sampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affine_bilinear_sampler: self-checking bench for the affine warp sampler
// Fills a corner block of the frame store and runs a directed table, then
// random writes and samples under several coefficient and size settings. Every
// result transfer is checked against a table value or an in-bench bilinear warp
// predictor, with random input gaps and random and forced output back-pressure.
// ----------------------------------------------------------------------------
module tb_affine_bilinear_sampler;
  import afbs_pkg::*;

  typedef struct {
    logic [15:0] value;
    logic [1:0]  chan;
    logic        last;
  } sample_t;

  typedef struct {
    op_t         op;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [1:0]  chan;
    logic [7:0]  pixel;
    bit          known;
    logic [15:0] value;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  logic signed [31:0] coef [6];
  logic [6:0]         src_w;
  logic [6:0]         src_h;
  logic [7:0]         shadow_store [4096];

  sample_t     pending_samples [$];
  int          mismatches = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_go = 1'b0;
  int          hold_left = 0;

  affine_bilinear_sampler DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_affine_bilinear_sampler failed");
    $finish;
  end

  function automatic longint clamp_size(logic [6:0] v);
    if (v < 2) return 2;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic logic [15:0] warp_sample(int col, int row);
    longint xs, ys, ix, iy, w, h, r0, r1, c0, c1;
    longint unsigned fx, fy, gx, gy, acc;
    w = clamp_size(src_w);
    h = clamp_size(src_h);
    xs = longint'(coef[0]) * col + longint'(coef[1]) * row + longint'(coef[2]);
    ys = longint'(coef[3]) * col + longint'(coef[4]) * row + longint'(coef[5]);
    ix = xs >>> 16;
    iy = ys >>> 16;
    fx = xs & 64'hFFFF;
    fy = ys & 64'hFFFF;
    gx = 65536 - fx;
    gy = 65536 - fy;
    if (iy >= 0 && iy < h - 1) begin
      r0 = iy;
      r1 = iy + 1;
    end else begin
      r0 = (iy < 0) ? 0 : h - 1;
      r1 = r0;
    end
    if (ix >= 0 && ix < w - 1) begin
      c0 = ix;
      c1 = ix + 1;
    end else begin
      c0 = (ix < 0) ? 0 : w - 1;
      c1 = c0;
    end
    acc = shadow_store[r0 * 64 + c0] * (gx * gy) + shadow_store[r0 * 64 + c1] * (fx * gy)
        + shadow_store[r1 * 64 + c0] * (gx * fy) + shadow_store[r1 * 64 + c1] * (fx * fy);
    return acc[39:24];
  endfunction

  // drive one item, predict on transfer
  task automatic transfer(op_t op, logic [5:0] col, logic [5:0] row, logic [1:0] chan,
                          logic [7:0] pixel, bit known = 0, logic [15:0] value = '0);
    sample_t s;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, pixel, row, col};
    s_tuser  <= {chan, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_WRITE) begin
      if (chan == 0) shadow_store[{row, col}] = pixel;
    end else begin
      s.value = known ? value : warp_sample(col, row);
      s.chan = 0;
      s.last = 1'b1;
      pending_samples = {pending_samples, s};
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] vals [8]);
    reg_t r;
    drain();
    for (int i = 0; i < 8; i++) begin
      r = reg_t'(i);
      cfg_we    <= 1'b1;
      cfg_addr  <= r;
      cfg_wdata <= vals[i];
      if (r == REG_WIDTH) src_w = vals[i][6:0];
      else if (r == REG_HEIGHT) src_h = vals[i][6:0];
      else coef[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_go) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0 && !hold_go) && ($urandom_range(99) >= recv_idle);
      if (m_tvalid && m_tready) begin
        if (pending_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%h chan=%0d last=%b", m_tdata, m_tuser, m_tlast);
        end else begin
          sample_t e;
          e = pending_samples.pop_front();
          if (m_tdata !== e.value || m_tuser !== e.chan || m_tlast !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                       e.value, e.chan, e.last, m_tdata, m_tuser, m_tlast);
          end
        end
      end
    end
  end

  vector_t directed [] = '{
    '{OP_WRITE,  6'd0,  6'd0,  2'd0, 8'h00, 0, 16'h0000},
    '{OP_WRITE,  6'd63, 6'd63, 2'd0, 8'hFF, 0, 16'h0000},
    '{OP_WRITE,  6'd0,  6'd63, 2'd0, 8'hFF, 0, 16'h0000},
    '{OP_WRITE,  6'd1,  6'd63, 2'd0, 8'hFF, 0, 16'h0000},
    '{OP_WRITE,  6'd63, 6'd0,  2'd0, 8'h00, 0, 16'h0000},
    '{OP_WRITE,  6'd63, 6'd1,  2'd0, 8'h00, 0, 16'h0000},
    '{OP_WRITE,  6'd5,  6'd5,  2'd0, 8'h5A, 0, 16'h0000},
    '{OP_WRITE,  6'd5,  6'd5,  2'd3, 8'hA5, 0, 16'h0000},
    '{OP_WRITE,  6'd6,  6'd5,  2'd1, 8'h11, 0, 16'h0000},
    '{OP_SAMPLE, 6'd0,  6'd0,  2'd0, 8'h00, 1, 16'h0000},
    '{OP_SAMPLE, 6'd63, 6'd63, 2'd3, 8'hFF, 1, 16'hFF00},
    '{OP_SAMPLE, 6'd63, 6'd0,  2'd0, 8'h00, 1, 16'h0000},
    '{OP_SAMPLE, 6'd0,  6'd63, 2'd0, 8'h00, 1, 16'hFF00},
    '{OP_SAMPLE, 6'd5,  6'd5,  2'd0, 8'h00, 1, 16'h5A00},
    '{OP_SAMPLE, 6'd6,  6'd5,  2'd0, 8'h00, 0, 16'h0000},
    '{OP_SAMPLE, 6'd6,  6'd6,  2'd0, 8'h00, 0, 16'h0000},
    '{OP_SAMPLE, 6'd3,  6'd2,  2'd0, 8'h00, 0, 16'h0000}
  };

  initial begin
    logic [31:0] setting [8];
    coef = '{32'sd65536, 0, 0, 0, 32'sd65536, 0};
    src_w = SIZE_RESET;
    src_h = SIZE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the top-left 8x8 block; sizes stay within it beyond the edge cases
    for (int i = 0; i < 64; i++)
      transfer(OP_WRITE, {3'b0, i[2:0]}, {3'b0, i[5:3]}, 2'd0, 8'($urandom_range(255)));
    foreach (directed[i])
      transfer(directed[i].op, directed[i].col, directed[i].row, directed[i].chan,
               directed[i].pixel, directed[i].known, directed[i].value);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: setting = '{32'h0001_8000, 32'hFFFF_C000, 32'hFFF6_0000, 32'h0000_4000,
                       32'h0000_E000, 32'h0002_8000, 32'd8, 32'd8};
        1: setting = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd127};
        2: setting = '{32'h0000_8000, 32'h0, 32'h0000_3000, 32'h0, 32'h0000_8000,
                       32'h0000_7FFF, 32'd2, 32'd2};
        3: setting = '{32'($urandom_range(196608)) - 32'd98304,
                       32'($urandom_range(196608)) - 32'd98304,
                       32'($urandom_range(8388608)) - 32'd4194304,
                       32'($urandom_range(196608)) - 32'd98304,
                       32'($urandom_range(196608)) - 32'd98304,
                       32'($urandom_range(8388608)) - 32'd4194304,
                       32'($urandom_range(8)), 32'($urandom_range(8))};
        4: setting = '{32'h0000_FFFF, 32'h0000_1234, 32'h0000_0001, 32'hFFFF_EDCC,
                       32'h0001_0001, 32'hFFFF_FFFF, 32'd7, 32'd5};
        default: setting = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             32'($urandom_range(8)), 32'($urandom_range(8))};
      endcase
      configure(setting);
      send_idle = (p < 2) ? 28 : (p < 4) ? 62 : 0;
      recv_idle = (p < 2) ? 62 : (p < 4) ? 28 : 0;
      if (p == 4) hold_go <= 1'b1;
      for (int n = 0; n < 45; n++) begin
        if (p == 4 && n == 1) hold_go <= 1'b0;
        if (p == 5 && n == 30) begin
          s_tvalid <= 1'b0;
          while (pending_samples.size() != 0) @(posedge clk);
        end
        if ($urandom_range(99) < 55)
          transfer(OP_SAMPLE, 6'($urandom_range(63)), 6'($urandom_range(63)),
                   2'($urandom_range(3)), 8'($urandom_range(255)));
        else
          transfer(OP_WRITE, 6'($urandom_range(63)), 6'($urandom_range(63)),
                   ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd0,
                   8'($urandom_range(255)));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0)
      $display("tb_affine_bilinear_sampler passed");
    else
      $display("tb_affine_bilinear_sampler failed");
    $finish;
  end

endmodule
